@@ hw/rtl/ctt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_pkg: shared types and constants of the contact track table
// Entry record, control and status groups between the ring cells, the head
// unit and the top level.
// ----------------------------------------------------------------------------
package ctt_pkg;

  localparam int unsigned TableDepthDefault = 32;
  localparam int unsigned KeyBitsDefault    = 16;

  localparam logic [15:0] MaxAgeReset = 16'd5000;
  localparam logic [15:0] AgeMax      = 16'hFFFF;

  // Input transaction opcodes
  localparam logic OpMerge = 1'b0;
  localparam logic OpTick  = 1'b1;

  // Payload of one table entry (key and valid bit travel separately)
  typedef struct packed {
    logic [7:0]  sensors;
    logic [7:0]  confidence;
    logic [3:0]  quality;
    logic [2:0]  kind;
    logic [2:0]  flags;     // bit0 missile, bit1 firing, bit2 threat
    logic [15:0] age;
  } ctt_entry_t;

  // Per-cell control
  typedef struct packed {
    logic shift;            // take the neighbor's entry
    logic wr;               // load the write port
  } ctt_cell_ctl_t;

  // Head unit status for the entry under inspection
  typedef struct packed {
    logic match;            // valid entry with the searched key
    logic free;             // slot not in use
    logic purge;            // entry freed by this tick
  } ctt_head_stat_t;

endpackage

@@ hw/rtl/ctt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_cell: one slot of the track ring
// Holds one entry; shifts in its neighbor's entry or loads a direct write.
// ----------------------------------------------------------------------------
module ctt_cell #(
  parameter int unsigned KeyBits = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ctt_pkg::ctt_cell_ctl_t ctl_i,
  input  logic                   shift_valid_i,
  input  logic [KeyBits-1:0]     shift_key_i,
  input  ctt_pkg::ctt_entry_t    shift_entry_i,
  input  logic [KeyBits-1:0]     wr_key_i,
  input  ctt_pkg::ctt_entry_t    wr_entry_i,
  output logic                   valid_o,
  output logic [KeyBits-1:0]     key_o,
  output ctt_pkg::ctt_entry_t    entry_o
);
  import ctt_pkg::*;

  logic               valid_q, valid_d;
  logic [KeyBits-1:0] key_q, key_d;
  ctt_entry_t         entry_q, entry_d;

  // Select shift, write or hold
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    entry_d = entry_q;
    if (ctl_i.shift) begin
      valid_d = shift_valid_i;
      key_d   = shift_key_i;
      entry_d = shift_entry_i;
    end else if (ctl_i.wr) begin
      valid_d = 1'b1;
      key_d   = wr_key_i;
      entry_d = wr_entry_i;
    end
  end

  // Valid bit clears on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign entry_o = entry_q;

endmodule

@@ hw/rtl/ctt_head.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_head: inspection unit at the head of the ring
// Ages and purges the passing entry on tick, matches its key on merge.
// ----------------------------------------------------------------------------
module ctt_head #(
  parameter int unsigned KeyBits = 16
) (
  input  logic                    op_i,
  input  logic [KeyBits-1:0]      key_i,
  input  logic [15:0]             elapsed_i,
  input  logic [15:0]             max_age_i,
  input  logic                    valid_i,
  input  logic [KeyBits-1:0]      entry_key_i,
  input  ctt_pkg::ctt_entry_t     entry_i,
  output logic                    valid_o,
  output ctt_pkg::ctt_entry_t     entry_o,
  output ctt_pkg::ctt_head_stat_t stat_o
);
  import ctt_pkg::*;

  logic [16:0] age_sum;
  logic [15:0] age_new;
  logic        expired;

  // Saturating age update
  assign age_sum = {1'b0, entry_i.age} + {1'b0, elapsed_i};
  assign age_new = age_sum[16] ? AgeMax : age_sum[15:0];
  assign expired = valid_i && (age_new > max_age_i);

  // Rewrite the entry on tick, pass it through on merge
  always_comb begin
    valid_o      = valid_i;
    entry_o      = entry_i;
    stat_o.match = 1'b0;
    stat_o.free  = !valid_i;
    stat_o.purge = 1'b0;
    if (op_i == OpTick) begin
      if (valid_i) begin
        entry_o.age = age_new;
      end
      valid_o      = valid_i && !expired;
      stat_o.purge = expired;
    end else begin
      stat_o.match = valid_i && (entry_key_i == key_i);
    end
  end

endmodule

@@ hw/rtl/contact_track_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contact_track_table: table of tracked contacts keyed by entity id, with aging
// Entries live in a ring of cells that rotates once past a head unit per item;
// merges hit or fill a slot, ticks age and purge entries.
// ----------------------------------------------------------------------------
//  Port group    Dir  Payload
//  s_axis_*      in   tuser opcode; tdata report and elapsed time
//  m_axis_*      out  tdata slot, status, merged entry, counts
//  cfg_*         in   max_age_ms register write
//
//  An item is handled in order: accept, one full rotation of the cell ring
//  past the single head unit, then a finish state that writes the chosen
//  slot and loads the output register. A new item is taken in idle while a
//  result still waits; finish holds while the output is stalled.
//  Reset empties the table and loads max_age_ms with 5000.
// ----------------------------------------------------------------------------
module contact_track_table #(
  parameter int unsigned TableDepth = ctt_pkg::TableDepthDefault,
  parameter int unsigned KeyBits    = ctt_pkg::KeyBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] entity_id, [23:16] sensor_bits, [31:24] confidence, [35:32] quality,
  // [38:36] contact_type, [39] missile_flag, [40] firing_flag,
  // [41] hostile_flag, [57:42] elapsed_ms, [63:58] zero
  input  logic [63:0] s_axis_tdata,
  // [0] opcode
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] slot, [5] is_new, [6] table_full, [14:7] merged_sensors,
  // [22:15] merged_confidence, [26:23] merged_quality, [29:27] merged_type,
  // [32:30] merged_flags, [38:33] purged_count, [44:39] live_count, [47:45] zero
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import ctt_pkg::*;

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam logic [IdxW-1:0] LastPos = IdxW'(TableDepth - 1);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StFinish = 2'd2;

  logic [1:0] state_q, state_d;

  // Latched input transaction
  logic               op_q;
  logic [KeyBits-1:0] key_q;
  logic [7:0]         sens_q;
  logic [7:0]         conf_q;
  logic [3:0]         qual_q;
  logic [2:0]         type_q;
  logic [2:0]         flags_q;
  logic [15:0]        elapsed_q;

  logic [15:0] max_age_q;

  // Scan bookkeeping
  logic [IdxW-1:0] pos_q;
  logic            hit_found_q, free_found_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q;
  ctt_entry_t      hit_entry_q;
  logic [CntW-1:0] purged_q, live_q, live_d;

  logic [47:0] out_data_q, out_data_d;
  logic        out_valid_q;

  // Ring signals
  logic               cell_valid [TableDepth];
  logic [KeyBits-1:0] cell_key   [TableDepth];
  ctt_entry_t         cell_entry [TableDepth];
  ctt_cell_ctl_t      cell_ctl   [TableDepth];

  logic           head_valid;
  ctt_entry_t     head_entry;
  ctt_head_stat_t head_stat;

  logic            in_go, scan, finish_go, wr_en, out_free;
  logic [IdxW-1:0] wr_idx;
  ctt_entry_t      merged_entry, new_entry, wr_entry;

  assign s_axis_tready = (state_q == StIdle);
  assign in_go         = s_axis_tvalid && s_axis_tready;
  assign scan          = (state_q == StScan);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign finish_go     = (state_q == StFinish) && out_free;

  // Head unit inspects the entry in cell zero
  ctt_head #(
    .KeyBits(KeyBits)
  ) u_head (
    .op_i        (op_q),
    .key_i       (key_q),
    .elapsed_i   (elapsed_q),
    .max_age_i   (max_age_q),
    .valid_i     (cell_valid[0]),
    .entry_key_i (cell_key[0]),
    .entry_i     (cell_entry[0]),
    .valid_o     (head_valid),
    .entry_o     (head_entry),
    .stat_o      (head_stat)
  );

  // Merge into a hit entry or build a fresh one
  always_comb begin
    merged_entry            = hit_entry_q;
    merged_entry.sensors    = hit_entry_q.sensors | sens_q;
    merged_entry.confidence = (conf_q > hit_entry_q.confidence) ? conf_q
                                                                : hit_entry_q.confidence;
    merged_entry.quality    = (qual_q > hit_entry_q.quality) ? qual_q : hit_entry_q.quality;
    merged_entry.kind       = (hit_entry_q.kind == 3'd0) ? type_q : hit_entry_q.kind;
    merged_entry.flags      = hit_entry_q.flags | flags_q;
    merged_entry.age        = 16'd0;

    new_entry.sensors    = sens_q;
    new_entry.confidence = conf_q;
    new_entry.quality    = qual_q;
    new_entry.kind       = type_q;
    new_entry.flags      = flags_q;
    new_entry.age        = 16'd0;
  end

  assign wr_en    = finish_go && (op_q == OpMerge) && (hit_found_q || free_found_q);
  assign wr_idx   = hit_found_q ? hit_idx_q : free_idx_q;
  assign wr_entry = hit_found_q ? merged_entry : new_entry;

  // Ring of cells, rotating toward cell zero; head output feeds the tail
  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    logic               sh_valid;
    logic [KeyBits-1:0] sh_key;
    ctt_entry_t         sh_entry;

    if (i == TableDepth - 1) begin : g_tail
      assign sh_valid = head_valid;
      assign sh_key   = cell_key[0];
      assign sh_entry = head_entry;
    end else begin : g_body
      assign sh_valid = cell_valid[i+1];
      assign sh_key   = cell_key[i+1];
      assign sh_entry = cell_entry[i+1];
    end

    assign cell_ctl[i].shift = scan;
    assign cell_ctl[i].wr    = wr_en && (wr_idx == IdxW'(i));

    ctt_cell #(
      .KeyBits(KeyBits)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (cell_ctl[i]),
      .shift_valid_i (sh_valid),
      .shift_key_i   (sh_key),
      .shift_entry_i (sh_entry),
      .wr_key_i      (key_q),
      .wr_entry_i    (wr_entry),
      .valid_o       (cell_valid[i]),
      .key_o         (cell_key[i]),
      .entry_o       (cell_entry[i])
    );
  end

  // Sequence accept, scan and finish
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (in_go) state_d = StScan;
      StScan:   if (pos_q == LastPos) state_d = StFinish;
      StFinish: if (out_free) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // Live count after this transaction
  always_comb begin
    live_d = live_q;
    if (op_q == OpTick) begin
      live_d = live_q - purged_q;
    end else if (!hit_found_q && free_found_q) begin
      live_d = live_q + CntW'(1);
    end
  end

  // Assemble the result
  always_comb begin
    logic [IdxW+4:0] slot_ext;
    logic [CntW+5:0] purged_ext;
    logic [CntW+5:0] live_ext;
    slot_ext   = {5'd0, wr_idx};
    purged_ext = {6'd0, purged_q};
    live_ext   = {6'd0, live_d};
    out_data_d = '0;
    out_data_d[44:39] = live_ext[5:0];
    if (op_q == OpTick) begin
      out_data_d[38:33] = purged_ext[5:0];
    end else if (hit_found_q || free_found_q) begin
      out_data_d[4:0]   = slot_ext[4:0];
      out_data_d[5]     = !hit_found_q;
      out_data_d[14:7]  = wr_entry.sensors;
      out_data_d[22:15] = wr_entry.confidence;
      out_data_d[26:23] = wr_entry.quality;
      out_data_d[29:27] = wr_entry.kind;
      out_data_d[32:30] = wr_entry.flags;
    end else begin
      out_data_d[6] = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      max_age_q    <= MaxAgeReset;
      pos_q        <= '0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      purged_q     <= '0;
      live_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        max_age_q <= cfg_wdata_i;
      end
      if (in_go) begin
        pos_q        <= '0;
        hit_found_q  <= 1'b0;
        free_found_q <= 1'b0;
        purged_q     <= '0;
      end else if (scan) begin
        pos_q <= (pos_q == LastPos) ? '0 : pos_q + IdxW'(1);
        if (head_stat.match && !hit_found_q) begin
          hit_found_q <= 1'b1;
        end
        if (head_stat.free && !free_found_q) begin
          free_found_q <= 1'b1;
        end
        if (head_stat.purge) begin
          purged_q <= purged_q + CntW'(1);
        end
      end
      if (finish_go) begin
        live_q      <= live_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: latched item, captured hit, result
  always_ff @(posedge clk_i) begin
    if (in_go) begin
      op_q      <= s_axis_tuser;
      key_q     <= KeyBits'(s_axis_tdata[15:0]);
      sens_q    <= s_axis_tdata[23:16];
      conf_q    <= s_axis_tdata[31:24];
      qual_q    <= s_axis_tdata[35:32];
      type_q    <= s_axis_tdata[38:36];
      flags_q   <= s_axis_tdata[41:39];
      elapsed_q <= s_axis_tdata[57:42];
    end
    if (scan && head_stat.match && !hit_found_q) begin
      hit_idx_q   <= pos_q;
      hit_entry_q <= cell_entry[0];
    end
    if (scan && head_stat.free && !free_found_q) begin
      free_idx_q <= pos_q;
    end
    if (finish_go) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the contact track table
// Streams merge reports and age ticks into the table and tracks a shadow copy
// of every slot to work out each result. Every result is compared field by
// field. The run walks several max_age_ms settings, including 0 and 65535, and
// several back-pressure patterns, among them one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import ctt_pkg::*;

  localparam int Depth    = 32;
  localparam int PoolSize = 40;
  localparam int HoldLen  = 400;

  typedef struct packed {
    logic        opcode;
    logic [15:0] id;
    logic [7:0]  sensors;
    logic [7:0]  conf;
    logic [3:0]  qual;
    logic [2:0]  kind;
    logic        missile;
    logic        firing;
    logic        hostile;
    logic [15:0] elapsed;
  } report_t;

  typedef struct packed {
    logic [4:0] slot;
    logic       is_new;
    logic       full;
    logic [7:0] sensors;
    logic [7:0] conf;
    logic [3:0] qual;
    logic [2:0] kind;
    logic [2:0] flags;
    logic [5:0] purged;
    logic [5:0] live;
  } track_status_t;

  typedef enum {GAP_NONE, GAP_SENDER, GAP_RECEIVER, GAP_BOTH} gap_mode_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic [15:0] cfg_wdata_i   = '0;

  // Shadow copy of the table
  bit          shadow_valid [Depth];
  logic [15:0] shadow_key   [Depth];
  logic [7:0]  shadow_sens  [Depth];
  logic [7:0]  shadow_conf  [Depth];
  logic [3:0]  shadow_qual  [Depth];
  logic [2:0]  shadow_kind  [Depth];
  logic [2:0]  shadow_flags [Depth];
  logic [15:0] shadow_age   [Depth];
  logic [15:0] shadow_max_age = MaxAgeReset;

  report_t       pending_reports [$];
  track_status_t expected_status [$];
  logic [15:0]   id_pool [PoolSize];

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  bit start_hold    = 1'b0;
  int hold_left     = 0;
  int errors        = 0;
  int n_checked     = 0;
  int n_new         = 0;
  int n_dropped     = 0;
  int n_purged      = 0;
  int n_ticks       = 0;
  int n_phases      = 0;

  contact_track_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Apply one transaction to the shadow table and return the status it yields
  function automatic track_status_t apply_report(report_t rp);
    track_status_t st;
    int            hit;
    int            fre;
    int unsigned   sum;
    logic [2:0]    fl;
    st  = '0;
    hit = -1;
    fre = -1;
    fl  = {rp.hostile, rp.firing, rp.missile};
    if (rp.opcode == OpTick) begin
      n_ticks++;
      for (int i = 0; i < Depth; i++) begin
        if (shadow_valid[i]) begin
          sum = 32'(shadow_age[i]) + 32'(rp.elapsed);
          shadow_age[i] = (sum > 32'(AgeMax)) ? AgeMax : sum[15:0];
          if (shadow_age[i] > shadow_max_age) begin
            shadow_valid[i] = 1'b0;
            st.purged++;
          end
        end
      end
      n_purged += int'(st.purged);
    end else begin
      for (int i = 0; i < Depth; i++) begin
        if (shadow_valid[i]) begin
          if (hit < 0 && shadow_key[i] == rp.id) hit = i;
        end else if (fre < 0) begin
          fre = i;
        end
      end
      if (hit >= 0) begin
        shadow_sens[hit]  |= rp.sensors;
        shadow_flags[hit] |= fl;
        if (rp.conf > shadow_conf[hit]) shadow_conf[hit] = rp.conf;
        if (rp.qual > shadow_qual[hit]) shadow_qual[hit] = rp.qual;
        if (shadow_kind[hit] == 3'd0) shadow_kind[hit] = rp.kind;
        shadow_age[hit] = '0;
      end else if (fre >= 0) begin
        hit               = fre;
        shadow_valid[hit] = 1'b1;
        shadow_key[hit]   = rp.id;
        shadow_sens[hit]  = rp.sensors;
        shadow_conf[hit]  = rp.conf;
        shadow_qual[hit]  = rp.qual;
        shadow_kind[hit]  = rp.kind;
        shadow_flags[hit] = fl;
        shadow_age[hit]   = '0;
        st.is_new         = 1'b1;
        n_new++;
      end else begin
        st.full = 1'b1;
        n_dropped++;
      end
      if (hit >= 0) begin
        st.slot    = hit[4:0];
        st.sensors = shadow_sens[hit];
        st.conf    = shadow_conf[hit];
        st.qual    = shadow_qual[hit];
        st.kind    = shadow_kind[hit];
        st.flags   = shadow_flags[hit];
      end
    end
    for (int i = 0; i < Depth; i++) st.live += 6'(shadow_valid[i]);
    return st;
  endfunction

  // Draw a report or tick; ids mostly come from a small pool so hits are common
  function automatic report_t rand_report(int tick_pct, int elap_max);
    report_t     rp;
    int          pick;
    logic [63:0] raw;
    raw        = {$urandom, $urandom};
    rp         = raw[$bits(report_t)-1:0];
    rp.opcode  = ($urandom_range(99) < tick_pct) ? OpTick : OpMerge;
    if ($urandom_range(9) != 0) rp.id = id_pool[$urandom_range(PoolSize - 1)];
    if (rp.opcode == OpTick) begin
      pick = $urandom_range(99);
      if (pick < 80)      rp.elapsed = 16'($urandom_range(elap_max, 0));
      else if (pick < 92) rp.elapsed = 16'($urandom);
      else                rp.elapsed = AgeMax;
    end
    return rp;
  endfunction

  task automatic queue_report(logic op, logic [15:0] id, logic [7:0] sens, logic [7:0] conf,
                              logic [3:0] qual, logic [2:0] kind, logic [2:0] fl,
                              logic [15:0] elap);
    report_t rp;
    rp              = '{op, id, sens, conf, qual, kind, fl[0], fl[1], fl[2], elap};
    pending_reports = {pending_reports, rp};
  endtask

  task automatic write_max_age(logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    shadow_max_age  = value;
  endtask

  task automatic set_gaps(gap_mode_e mode);
    src_idle_pct  = (mode == GAP_SENDER || mode == GAP_RECEIVER) ?
                    ((mode == GAP_SENDER) ? 53 : 0) : ((mode == GAP_BOTH) ? 7 : 0);
    sink_idle_pct = (mode == GAP_RECEIVER) ? 53 : ((mode == GAP_BOTH) ? 7 : 0);
  endtask

  // Hold until every queued transaction is accepted and answered
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_reports.size() != 0 || s_axis_tvalid || expected_status.size() != 0 ||
           start_hold || hold_left != 0);
  endtask

  task automatic run_phase(gap_mode_e mode, logic [15:0] max_age, int n_items,
                           int tick_pct, int elap_max, bit pressure);
    set_gaps(mode);
    write_max_age(max_age);
    for (int i = 0; i < PoolSize; i++) id_pool[i] = 16'($urandom);
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    if (pressure) start_hold = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      pending_reports = {pending_reports, rand_report(tick_pct, elap_max)};
    end
    wait_drained();
    n_phases++;
  endtask

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Driver: offer the head of the pending queue, hold it until accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_status = {expected_status, apply_report(pending_reports.pop_front())};
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reports.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= pending_reports[0].opcode;
          s_axis_tdata  <= {6'd0, pending_reports[0].elapsed, pending_reports[0].hostile,
                            pending_reports[0].firing, pending_reports[0].missile,
                            pending_reports[0].kind, pending_reports[0].qual,
                            pending_reports[0].conf, pending_reports[0].sensors,
                            pending_reports[0].id};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Monitor: compare each result transaction, then choose the next tready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_status.size() == 0) begin
          $error("result transaction with no expected status waiting");
          errors++;
        end else begin
          check_field("slot", 32'(expected_status[0].slot), 32'(m_axis_tdata[4:0]));
          check_field("is_new", 32'(expected_status[0].is_new), 32'(m_axis_tdata[5]));
          check_field("table_full", 32'(expected_status[0].full), 32'(m_axis_tdata[6]));
          check_field("merged_sensors", 32'(expected_status[0].sensors),
                      32'(m_axis_tdata[14:7]));
          check_field("merged_confidence", 32'(expected_status[0].conf),
                      32'(m_axis_tdata[22:15]));
          check_field("merged_quality", 32'(expected_status[0].qual),
                      32'(m_axis_tdata[26:23]));
          check_field("merged_type", 32'(expected_status[0].kind),
                      32'(m_axis_tdata[29:27]));
          check_field("merged_flags", 32'(expected_status[0].flags),
                      32'(m_axis_tdata[32:30]));
          check_field("purged_count", 32'(expected_status[0].purged),
                      32'(m_axis_tdata[38:33]));
          check_field("live_count", 32'(expected_status[0].live),
                      32'(m_axis_tdata[44:39]));
          void'(expected_status.pop_front());
          n_checked++;
        end
      end
      if (start_hold) begin
        hold_left  = HoldLen;
        start_hold = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Stimulus sequence
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, default max_age_ms of 5000
    queue_report(OpMerge, 16'h1234, 8'h01, 8'd100, 4'd5, 3'd0, 3'b001, 16'h0000);
    // hit: larger stored confidence kept, larger quality taken, unknown type adopted
    queue_report(OpMerge, 16'h1234, 8'h80, 8'd50, 4'd9, 3'd3, 3'b010, 16'hFFFF);
    // hit: known type kept, threat flag ORed in
    queue_report(OpMerge, 16'h1234, 8'h00, 8'd200, 4'd2, 3'd6, 3'b100, 16'h0000);
    queue_report(OpMerge, 16'h0000, 8'h00, 8'd0, 4'd0, 3'd0, 3'b000, 16'h0000);
    queue_report(OpMerge, 16'hFFFF, 8'hFF, 8'd255, 4'd15, 3'd7, 3'b111, 16'hFFFF);
    queue_report(OpTick, 16'h0000, 8'h00, 8'd0, 4'd0, 3'd0, 3'b000, 16'd4000);
    queue_report(OpMerge, 16'h1234, 8'h00, 8'd0, 4'd0, 3'd0, 3'b000, 16'h0000);
    queue_report(OpTick, 16'h0000, 8'h00, 8'd0, 4'd0, 3'd0, 3'b000, 16'd1001);
    // tick with every other field set, all ignored
    queue_report(OpTick, 16'hFFFF, 8'hFF, 8'd255, 4'd15, 3'd7, 3'b111, 16'd0);
    queue_report(OpMerge, 16'h0000, 8'h5A, 8'd17, 4'd3, 3'd2, 3'b101, 16'h0000);
    // age equal to the limit survives, one past it is purged
    queue_report(OpTick, 16'h0000, 8'h00, 8'd0, 4'd0, 3'd0, 3'b000, 16'd3999);
    queue_report(OpTick, 16'h0000, 8'h00, 8'd0, 4'd0, 3'd0, 3'b000, 16'd1);
    // saturating age
    queue_report(OpTick, 16'h0000, 8'h00, 8'd0, 4'd0, 3'd0, 3'b000, 16'hFFFF);
    queue_report(OpMerge, 16'h8000, 8'hA5, 8'd128, 4'd8, 3'd4, 3'b010, 16'h8000);
    wait_drained();
    n_phases++;

    // Random part across register settings and back-pressure patterns
    run_phase(GAP_NONE,     16'd1000,  250, 15, 400,   1'b0);
    run_phase(GAP_SENDER,   16'hFFFF,  250, 15, 65535, 1'b0);
    run_phase(GAP_RECEIVER, 16'd0,     200, 25, 2,     1'b0);
    run_phase(GAP_BOTH,     16'd300,   250, 15, 120,   1'b0);
    run_phase(GAP_NONE,     16'd2000,  200, 12, 700,   1'b1);
    run_phase(GAP_BOTH,     16'($urandom), 250, 15, 30000, 1'b0);
    run_phase(GAP_SENDER,   MaxAgeReset, 250, 15, 1500, 1'b0);

    repeat (3 * (Depth + 2)) @(posedge clk_i);
    $display("summary: %0d results checked in %0d phases, %0d ticks, %0d purged",
             n_checked, n_phases, n_ticks, n_purged);
    $display("summary: %0d contacts filled, %0d dropped on a full table", n_new, n_dropped);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("testbench: errors");
    $finish;
  end

endmodule
